### hdl/ksd_pkg.sv
package ksd_pkg;

    // scanner state codes
    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_PRESSED  = 3'd1,
        ST_DEBOUNCE = 3'd2,
        ST_DECODE   = 3'd3,
        ST_WAIT_REL = 3'd4,
        ST_REL_DEB  = 3'd5,
        ST_RELEASED = 3'd6
    } t_scan_state;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRESS_DEB   = 2'd0,
        CFG_RELEASE_DEB = 2'd1
    } t_cfg_index;

    localparam int MS_W = 7;
    localparam logic [MS_W-1:0] MS_MAX          = 7'd127;
    localparam logic [MS_W-1:0] PRESS_DEB_RST   = 7'd30;
    localparam logic [MS_W-1:0] RELEASE_DEB_RST = 7'd70;

    // scanner registers as one group
    typedef struct packed {
        t_scan_state     state;
        logic [1:0]      row_index;
        logic [1:0]      captured_column;
        logic [MS_W-1:0] ms_count;
        logic            timer_running;
        logic            prev_key_line;
        logic [7:0]      held_key_code;
    } t_scan_regs;

    // one result item
    typedef struct packed {
        logic [1:0] row_select;
        logic       key_found;
        logic [7:0] key_code;
    } t_scan_result;

    // key matrix to ascii, index is {row, column position}
    function automatic logic [7:0] key_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = "F";
            4'd1:    c = "E";
            4'd2:    c = "D";
            4'd3:    c = "C";
            4'd4:    c = "3";
            4'd5:    c = "6";
            4'd6:    c = "9";
            4'd7:    c = "B";
            4'd8:    c = "2";
            4'd9:    c = "5";
            4'd10:   c = "8";
            4'd11:   c = "0";
            4'd12:   c = "1";
            4'd13:   c = "4";
            4'd14:   c = "7";
            default: c = "A";
        endcase
        return c;
    endfunction

endpackage

### hdl/ksd_step.sv
module ksd_step (
    input  ksd_pkg::t_scan_regs           i_regs,
    input  logic                          i_key_line,
    input  logic [1:0]                    i_column_code,
    input  logic                          i_ms_tick,
    input  logic [ksd_pkg::MS_W-1:0]      i_press_deb,
    input  logic [ksd_pkg::MS_W-1:0]      i_release_deb,
    output ksd_pkg::t_scan_regs           o_regs,
    output ksd_pkg::t_scan_result         o_result
);
    import ksd_pkg::*;

    t_scan_regs t;
    logic       found;

    always_comb begin
        t     = i_regs;
        found = 1'b0;

        // millisecond timer, restarted on any key line edge
        if (i_key_line != i_regs.prev_key_line) begin
            t.ms_count      = '0;
            t.timer_running = 1'b1;
        end else if (i_regs.timer_running && i_ms_tick && (i_regs.ms_count < MS_MAX)) begin
            t.ms_count = i_regs.ms_count + 1'b1;
        end
        t.prev_key_line = i_key_line;

        // scan state machine step
        case (i_regs.state)
            ST_IDLE: begin
                if (i_key_line) begin
                    t.state    = ST_PRESSED;
                    t.ms_count = '0;
                end else begin
                    t.row_index = i_regs.row_index + 1'b1;
                end
            end
            ST_PRESSED: begin
                if (i_key_line) begin
                    t.captured_column = i_column_code;
                    t.state           = ST_DEBOUNCE;
                end else begin
                    t.state = ST_IDLE;
                end
            end
            ST_DEBOUNCE: begin
                if ((t.ms_count >= i_press_deb) && (i_column_code == i_regs.captured_column)
                        && i_key_line) begin
                    t.state = ST_DECODE;
                end else begin
                    t.state = ST_PRESSED;
                end
            end
            ST_DECODE: begin
                t.held_key_code = key_char({i_regs.row_index, ~i_regs.captured_column});
                t.state         = ST_WAIT_REL;
            end
            ST_WAIT_REL: begin
                t.state = i_key_line ? ST_REL_DEB : ST_RELEASED;
            end
            ST_REL_DEB: begin
                if ((t.ms_count >= i_release_deb) && !i_key_line) begin
                    t.state = ST_RELEASED;
                end
            end
            ST_RELEASED: begin
                t.state         = ST_IDLE;
                t.row_index     = '0;
                t.timer_running = 1'b0;
                found           = 1'b1;
            end
            default: begin
                t.state     = ST_IDLE;
                t.row_index = '0;
            end
        endcase
    end

    assign o_regs              = t;
    assign o_result.row_select = t.row_index;
    assign o_result.key_found  = found;
    assign o_result.key_code   = t.held_key_code;

endmodule

### hdl/keypad_scan_debounce_unit.sv
// keypad scanner with press and release debounce, one poll sample per item
// input channel: i_in_valid / o_in_ready carry key_line, column_code and
//   ms_tick for the row that was selected by the previous result
// output channel: o_out_valid / i_out_ready carry row_select, key_found
//   (one-item pulse when a press and release completes) and key_code
// config channel: i_cfg_valid / o_cfg_ready, index 0 is press debounce ms,
//   index 1 is release debounce ms; o_cfg_ready is always high, write only
//   while no item is in flight
// an item's result is registered and shown in the cycle after its transfer
// throughput: one item per cycle unless stalled, the whole scanner step is
//   one short combinational stage between the scanner and output registers
// stall: the output register holds its item while i_out_ready is low and
//   o_in_ready drops until it is taken; o_in_ready stays high whenever the
//   output register is empty or being taken in the same cycle
// reset: synchronous, scanner idle on row 0, timer cleared, key code 0,
//   debounce times 30 and 70 ms, output register empty
module keypad_scan_debounce_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_key_line,
    input  logic [1:0]                    i_column_code,
    input  logic                          i_ms_tick,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_row_select,
    output logic                          o_key_found,
    output logic [7:0]                    o_key_code,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [ksd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ksd_pkg::MS_W-1:0]      i_cfg_data
);
    import ksd_pkg::*;

    t_scan_regs      r_regs, n_regs;
    t_scan_result    r_result, n_result;
    logic            r_out_valid;
    logic [MS_W-1:0] r_press_deb;
    logic [MS_W-1:0] r_release_deb;
    logic            in_xfer;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // next scanner state and result for the incoming sample
    ksd_step u_step (
        .i_regs        (r_regs),
        .i_key_line    (i_key_line),
        .i_column_code (i_column_code),
        .i_ms_tick     (i_ms_tick),
        .i_press_deb   (r_press_deb),
        .i_release_deb (r_release_deb),
        .o_regs        (n_regs),
        .o_result      (n_result)
    );

    // scanner registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.state           <= ST_IDLE;
            r_regs.row_index       <= '0;
            r_regs.captured_column <= '0;
            r_regs.ms_count        <= '0;
            r_regs.timer_running   <= 1'b0;
            r_regs.prev_key_line   <= 1'b0;
            r_regs.held_key_code   <= '0;
        end else if (in_xfer) begin
            r_regs <= n_regs;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_result <= n_result;
        end
    end

    // debounce time registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_deb   <= PRESS_DEB_RST;
            r_release_deb <= RELEASE_DEB_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PRESS_DEB:   r_press_deb   <= i_cfg_data;
                CFG_RELEASE_DEB: r_release_deb <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row_select = r_result.row_select;
    assign o_key_found  = r_result.key_found;
    assign o_key_code   = r_result.key_code;

endmodule

### hdl/ksd_checker.sv
module ksd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_row_select,
    input logic       o_key_found,
    input logic [7:0] o_key_code
);

    // a completed release always returns the scan to the first row
    a_found_row0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_key_found |-> o_row_select == 2'd0)
        else $error("key_found with nonzero row_select");

    // a reported key is never followed directly by another report
    a_found_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_key_found |=> !(o_out_valid && o_key_found))
        else $error("key_found on two consecutive items");

    // empty output stage must take input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

    // every input transfer shows up as a result on the next cycle
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("input transfer produced no result");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_row_select)
            && $stable(o_key_found) && $stable(o_key_code))
        else $error("stalled result changed");

endmodule

bind keypad_scan_debounce_unit ksd_checker u_ksd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_row_select (o_row_select),
    .o_key_found  (o_key_found),
    .o_key_code   (o_key_code)
);

### tb/tb_keypad_scan_debounce_unit.sv
`timescale 1ns / 100ps

module tb_keypad_scan_debounce_unit;
    import ksd_pkg::*;

    // one poll of the keypad pins
    typedef struct packed {
        logic       line;
        logic [1:0] col;
        logic       tick;
    } t_poll;

    // receiver pacing styles
    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_HALF,
        PACE_SPARSE,
        PACE_BURSTY
    } t_pace;

    // key characters in matrix order, first character in the top byte
    localparam logic [127:0] KEY_MAP = "FEDC369B2580147A";
    localparam int KEYSTROKE_PHASES = 8;
    localparam int POLLS_PER_PHASE  = 150;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic       i_key_line = 1'b0;
    logic [1:0] i_column_code = 2'd0;
    logic       i_ms_tick = 1'b0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b1;
    logic [1:0] o_row_select;
    logic       o_key_found;
    logic [7:0] o_key_code;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_cfg_index i_cfg_index;
    logic [MS_W-1:0] i_cfg_data;

    keypad_scan_debounce_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_key_line    (i_key_line),
        .i_column_code (i_column_code),
        .i_ms_tick     (i_ms_tick),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_row_select  (o_row_select),
        .o_key_found   (o_key_found),
        .o_key_code    (o_key_code),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    t_poll        polls_to_send[$];
    t_scan_result scans_due[$];

    int err_count      = 0;
    int polls_queued   = 0;
    int polls_sent     = 0;
    int keys_reported  = 0;
    int cfg_writes     = 0;
    int settings_used  = 0;

    // scanner shadow state
    t_scan_state     scan_st   = ST_IDLE;
    logic [1:0]      row_q     = 2'd0;
    logic [1:0]      col_q     = 2'd0;
    logic [MS_W-1:0] ms_q      = '0;
    logic            tmr_on    = 1'b0;
    logic            line_q    = 1'b0;
    logic [7:0]      code_q    = 8'd0;
    logic [MS_W-1:0] press_deb = PRESS_DEB_RST;
    logic [MS_W-1:0] rel_deb   = RELEASE_DEB_RST;

    // sender burst and receiver pacing
    int    burst_left;
    int    gap_left;
    t_pace pace_mode;
    int    pace_left;
    int    stall_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // advance the shadow scanner by one poll and return the expected result
    function automatic t_scan_result predict_scan(input logic line, input logic [1:0] col,
                                                  input logic tick);
        t_scan_result r;
        logic         found;
        int           idx;
        found = 1'b0;
        // debounce timer restarts on any edge of the key line
        if (line != line_q) begin
            ms_q   = '0;
            tmr_on = 1'b1;
        end else if (tmr_on && tick && ms_q != MS_MAX) begin
            ms_q = ms_q + 1'b1;
        end
        line_q = line;
        case (scan_st)
            ST_IDLE: begin
                if (line) begin
                    scan_st = ST_PRESSED;
                    ms_q    = '0;
                end else begin
                    row_q = row_q + 1'b1;
                end
            end
            ST_PRESSED: begin
                if (line) begin
                    col_q   = col;
                    scan_st = ST_DEBOUNCE;
                end else begin
                    scan_st = ST_IDLE;
                end
            end
            ST_DEBOUNCE: begin
                if (ms_q >= press_deb && col == col_q && line)
                    scan_st = ST_DECODE;
                else
                    scan_st = ST_PRESSED;
            end
            ST_DECODE: begin
                // column code 3 is the first column
                idx     = {row_q, ~col_q};
                code_q  = KEY_MAP[127 - 8*idx -: 8];
                scan_st = ST_WAIT_REL;
            end
            ST_WAIT_REL: begin
                scan_st = line ? ST_REL_DEB : ST_RELEASED;
            end
            ST_REL_DEB: begin
                if (ms_q >= rel_deb && !line)
                    scan_st = ST_RELEASED;
            end
            ST_RELEASED: begin
                scan_st = ST_IDLE;
                row_q   = 2'd0;
                tmr_on  = 1'b0;
                found   = 1'b1;
            end
            default: begin
                scan_st = ST_IDLE;
                row_q   = 2'd0;
            end
        endcase
        r.row_select = row_q;
        r.key_found  = found;
        r.key_code   = code_q;
        return r;
    endfunction

    task automatic push_poll(input logic line, input logic [1:0] col, input logic tick);
        t_poll p;
        p.line = line;
        p.col  = col;
        p.tick = tick;
        polls_to_send.push_back(p);
        polls_queued++;
    endtask

    // idle polls with the odd short blip on the key line
    task automatic queue_idle_noise();
        int n;
        n = $urandom_range(0, 6);
        repeat (n) push_poll($urandom_range(0, 7) == 0, 2'($urandom_range(0, 3)),
                             1'($urandom_range(0, 1)));
    endtask

    // one key press and release with contact bounce, sized to the debounce times
    task automatic queue_keystroke(input int press_ms, input int release_ms);
        logic [1:0] col;
        int         n;
        int         hold;
        int         rel;
        col = 2'($urandom_range(0, 3));
        n = $urandom_range(0, 4);
        repeat (n) push_poll(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                             1'($urandom_range(0, 1)));
        // cut short, held long enough to saturate the counter, or a normal press
        if ($urandom_range(0, 4) == 0)
            hold = $urandom_range(1, press_ms + 2);
        else if ($urandom_range(0, 9) == 0)
            hold = press_ms + $urandom_range(130, 150);
        else
            hold = press_ms + press_ms / 4 + $urandom_range(3, 8);
        for (int i = 0; i < hold; i++)
            push_poll(1'b1, ($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 3)) : col,
                      $urandom_range(0, 7) != 0);
        n = $urandom_range(0, 3);
        repeat (n) push_poll(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                             1'($urandom_range(0, 1)));
        if ($urandom_range(0, 5) == 0)
            rel = $urandom_range(0, release_ms);
        else
            rel = release_ms + release_ms / 4 + $urandom_range(2, 6);
        for (int i = 0; i < rel; i++)
            push_poll(1'b0, 2'($urandom_range(0, 3)), $urandom_range(0, 7) != 0);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (polls_to_send.size() != 0 || i_in_valid || scans_due.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [MS_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
    endtask

    task automatic set_debounce(input int press_ms, input int release_ms);
        write_reg(CFG_PRESS_DEB, MS_W'(press_ms));
        write_reg(CFG_RELEASE_DEB, MS_W'(release_ms));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // input driver, bursts of transfers with random gaps
    always @(posedge i_clk) begin : driver
        logic  nxt_valid;
        t_poll p;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end else if (!i_in_valid || o_in_ready) begin
            nxt_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (polls_to_send.size() > 0) begin
                p = polls_to_send.pop_front();
                i_key_line    <= p.line;
                i_column_code <= p.col;
                i_ms_tick     <= p.tick;
                nxt_valid = 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            i_in_valid <= nxt_valid;
        end
    end

    // output ready pacing, switches to a random style when its pace count runs out
    always @(posedge i_clk) begin : sink_pace
        if (!i_rst_n) begin
            i_out_ready <= 1'b1;
            pace_mode  = PACE_FREE;
            pace_left  = 0;
            stall_left = 0;
        end else begin
            if (pace_left == 0) begin
                pace_mode = t_pace'($urandom_range(0, 3));
                pace_left = $urandom_range(50, 250);
            end else begin
                pace_left--;
            end
            case (pace_mode)
                PACE_FREE:   i_out_ready <= 1'b1;
                PACE_HALF:   i_out_ready <= 1'($urandom_range(0, 1));
                PACE_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        i_out_ready <= 1'b0;
                    end else if ($urandom_range(0, 7) == 0) begin
                        stall_left = $urandom_range(1, 12);
                        i_out_ready <= 1'b0;
                    end else begin
                        i_out_ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    // result checker, register write tracking and prediction on each transfer
    always @(posedge i_clk) begin : monitor
        t_scan_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (scans_due.size() == 0) begin
                    $error("result transfer with no scan pending");
                    err_count++;
                end else begin
                    want = scans_due.pop_front();
                    if (o_row_select !== want.row_select) begin
                        $error("row_select: expected %0d, actual %0d",
                               want.row_select, o_row_select);
                        err_count++;
                    end
                    if (o_key_found !== want.key_found) begin
                        $error("key_found: expected %0d, actual %0d",
                               want.key_found, o_key_found);
                        err_count++;
                    end
                    if (o_key_code !== want.key_code) begin
                        $error("key_code: expected 0x%02h, actual 0x%02h",
                               want.key_code, o_key_code);
                        err_count++;
                    end
                    if (want.key_found)
                        keys_reported++;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PRESS_DEB:   press_deb = i_cfg_data;
                    CFG_RELEASE_DEB: rel_deb   = i_cfg_data;
                    default: ;
                endcase
                cfg_writes++;
            end
            if (i_in_valid && o_in_ready) begin
                scans_due.push_back(predict_scan(i_key_line, i_column_code, i_ms_tick));
                polls_sent++;
            end
        end
    end

    initial begin : stimulus
        int press_ms;
        int release_ms;
        int phase_start;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PRESS_DEB;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset debounce times: field extremes, press found while idle,
        // column mismatch during debounce, bounce back to idle
        push_poll(1'b0, 2'd3, 1'b1);
        push_poll(1'b0, 2'd0, 1'b0);
        push_poll(1'b1, 2'd3, 1'b1);
        push_poll(1'b1, 2'd0, 1'b1);
        push_poll(1'b1, 2'd3, 1'b0);
        push_poll(1'b0, 2'd2, 1'b0);
        push_poll(1'b0, 2'd1, 1'b1);
        wait_drained();

        // zero debounce: edge on the release poll, then a press decoded with the
        // timer stopped and a release seen while waiting for it
        set_debounce(0, 0);
        push_poll(1'b1, 2'd2, 1'b0);
        push_poll(1'b1, 2'd2, 1'b1);
        push_poll(1'b1, 2'd2, 1'b0);
        push_poll(1'b1, 2'd0, 1'b1);
        push_poll(1'b1, 2'd3, 1'b1);
        push_poll(1'b0, 2'd3, 1'b0);
        push_poll(1'b1, 2'd1, 1'b1);
        push_poll(1'b1, 2'd1, 1'b1);
        push_poll(1'b1, 2'd1, 1'b0);
        push_poll(1'b1, 2'd1, 1'b1);
        push_poll(1'b0, 2'd0, 1'b0);
        push_poll(1'b0, 2'd0, 1'b1);
        push_poll(1'b0, 2'd2, 1'b1);
        push_poll(1'b0, 2'd3, 1'b1);
        wait_drained();

        // keystroke phases over a spread of debounce settings
        for (int ph = 0; ph < KEYSTROKE_PHASES; ph++) begin
            case (ph)
                0: begin press_ms = 127; release_ms = 127; end
                1: begin press_ms = 0;   release_ms = 0;   end
                2: begin press_ms = PRESS_DEB_RST; release_ms = RELEASE_DEB_RST; end
                3: begin press_ms = 3;   release_ms = 1;   end
                4: begin press_ms = 0;   release_ms = 127; end
                default: begin
                    press_ms   = $urandom_range(0, 12);
                    release_ms = $urandom_range(0, 12);
                end
            endcase
            set_debounce(press_ms, release_ms);
            phase_start = polls_queued;
            while (polls_queued - phase_start < POLLS_PER_PHASE) begin
                queue_idle_noise();
                queue_keystroke(press_ms, release_ms);
            end
            queue_idle_noise();
            wait_drained();
        end

        $display("covered %0d keypad polls with %0d debounced key reports",
                 polls_sent, keys_reported);
        $display("over %0d debounce settings (%0d register writes)",
                 settings_used, cfg_writes);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
hdl/ksd_pkg.sv
hdl/ksd_step.sv
hdl/keypad_scan_debounce_unit.sv
hdl/ksd_checker.sv
tb/tb_keypad_scan_debounce_unit.sv
